FILE: hw/rtl/http_request_line_stats_macros.svh
// Assertion macros shared by the checker of the request line statistics block.
// No dependencies; included by the files that carry assertions.
`ifndef HTTP_REQUEST_LINE_STATS_MACROS_SVH
`define HTTP_REQUEST_LINE_STATS_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HRLS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HRLS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/hrls_pkg.sv
// Types, name tables and match functions for the request line statistics block.
// No dependencies; used by the parser, the counter bank and the top level.
package hrls_pkg;

  localparam int unsigned VIEW_BITS = 32;
  localparam logic [7:0] SPACE_BYTE = 8'h20;
  localparam int unsigned METHOD_KINDS = 4;
  localparam int unsigned PATH_KINDS = 5;
  localparam logic [3:0] INDEX_MAX = 4'd15;

  // Parser phase, one-hot.
  typedef enum logic [3:0] {
    PH_LEAD   = 4'b0001,
    PH_METHOD = 4'b0010,
    PH_URI    = 4'b0100,
    PH_REST   = 4'b1000
  } phase_e;

  typedef enum logic [2:0] {
    M_GET    = 3'd0,
    M_POST   = 3'd1,
    M_DELETE = 3'd2,
    M_PUT    = 3'd3,
    M_OTHER  = 3'd4
  } method_e;

  typedef enum logic [2:0] {
    P_ROOT    = 3'd0,
    P_ORDER   = 3'd1,
    P_PRODUCT = 3'd2,
    P_BASKET  = 3'd3,
    P_HELP    = 3'd4,
    P_OTHER   = 3'd5
  } path_e;

  // Counter increments requested by one byte.
  typedef struct packed {
    logic    m_inc;
    method_e m_sel;
    logic    p_inc;
    path_e   p_sel;
  } bump_t;

  // Names are right-justified: the first character sits in the highest used byte.
  localparam logic [63:0] METHOD_TEXT [METHOD_KINDS] = '{"GET", "POST", "DELETE", "PUT"};
  localparam logic [3:0]  METHOD_LEN  [METHOD_KINDS] = '{4'd3, 4'd4, 4'd6, 4'd3};
  localparam logic [63:0] PATH_TEXT [PATH_KINDS] =
    '{"/", "/order", "/product", "/basket", "/help"};
  localparam logic [3:0]  PATH_LEN  [PATH_KINDS] = '{4'd1, 4'd6, 4'd8, 4'd7, 4'd5};

  function automatic logic [METHOD_KINDS-1:0] method_hits(logic [3:0] idx, logic [7:0] b);
    logic [METHOD_KINDS-1:0] hit;
    logic [2:0] pos;
    hit = '0;
    for (int k = 0; k < METHOD_KINDS; k++) begin
      pos = 3'(METHOD_LEN[k] - 4'd1 - idx);
      hit[k] = (idx < METHOD_LEN[k]) && (METHOD_TEXT[k][8*pos +: 8] == b);
    end
    return hit;
  endfunction

  function automatic logic [PATH_KINDS-1:0] path_hits(logic [3:0] idx, logic [7:0] b);
    logic [PATH_KINDS-1:0] hit;
    logic [2:0] pos;
    hit = '0;
    for (int k = 0; k < PATH_KINDS; k++) begin
      pos = 3'(PATH_LEN[k] - 4'd1 - idx);
      hit[k] = (idx < PATH_LEN[k]) && (PATH_TEXT[k][8*pos +: 8] == b);
    end
    return hit;
  endfunction

  // The lowest surviving name whose length equals the token length wins.
  function automatic method_e method_pick(logic [METHOD_KINDS-1:0] cand, logic [3:0] idx);
    method_e sel;
    sel = M_OTHER;
    for (int k = METHOD_KINDS - 1; k >= 0; k--) begin
      if (cand[k] && (METHOD_LEN[k] == idx)) begin
        sel = method_e'(3'(k));
      end
    end
    return sel;
  endfunction

  function automatic path_e path_pick(logic [PATH_KINDS-1:0] cand, logic [3:0] idx);
    path_e sel;
    sel = P_OTHER;
    for (int k = PATH_KINDS - 1; k >= 0; k--) begin
      if (cand[k] && (PATH_LEN[k] == idx)) begin
        sel = path_e'(3'(k));
      end
    end
    return sel;
  endfunction

endpackage

FILE: hw/rtl/hrls_parser.sv
// Request line tokenizer: phase, token index and candidate masks.
// Depends on hrls_pkg; emits per-byte counter increments to hrls_counters.
module hrls_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  logic [7:0]        byte_i,
  input  logic              eol_i,
  output hrls_pkg::bump_t   bump_o
);

  hrls_pkg::phase_e                      phase_q, phase_d, phase_a;
  logic [3:0]                            idx_q, idx_d, idx_a;
  logic [hrls_pkg::METHOD_KINDS-1:0]     mc_q, mc_d, mc_a;
  logic [hrls_pkg::PATH_KINDS-1:0]       pc_q, pc_d, pc_a;
  hrls_pkg::bump_t                       bump;
  logic                                  sp;
  logic [3:0]                            idx_inc;

  assign sp      = (byte_i == hrls_pkg::SPACE_BYTE);
  assign idx_inc = (idx_q == hrls_pkg::INDEX_MAX) ? idx_q : idx_q + 4'd1;

  always_comb begin
    phase_a = phase_q;
    idx_a   = idx_q;
    mc_a    = mc_q;
    pc_a    = pc_q;
    bump    = '{m_inc: 1'b0, m_sel: hrls_pkg::M_OTHER, p_inc: 1'b0, p_sel: hrls_pkg::P_OTHER};

    unique case (phase_q)
      hrls_pkg::PH_LEAD: begin
        if (!sp) begin
          phase_a = hrls_pkg::PH_METHOD;
          mc_a    = hrls_pkg::method_hits(4'd0, byte_i);
          idx_a   = 4'd1;
        end
      end
      hrls_pkg::PH_METHOD: begin
        if (sp) begin
          bump.m_inc = 1'b1;
          bump.m_sel = hrls_pkg::method_pick(mc_q, idx_q);
          phase_a    = hrls_pkg::PH_URI;
          idx_a      = 4'd0;
          pc_a       = '1;
        end else begin
          mc_a  = mc_q & hrls_pkg::method_hits(idx_q, byte_i);
          idx_a = idx_inc;
        end
      end
      hrls_pkg::PH_URI: begin
        if (sp) begin
          bump.p_inc = 1'b1;
          bump.p_sel = hrls_pkg::path_pick(pc_q, idx_q);
          phase_a    = hrls_pkg::PH_REST;
        end else begin
          pc_a  = pc_q & hrls_pkg::path_hits(idx_q, byte_i);
          idx_a = idx_inc;
        end
      end
      hrls_pkg::PH_REST: begin
      end
      default: begin
      end
    endcase

    // At the end of the line, close whatever token is still open. A line that
    // never reached its URI counts that URI as unknown.
    if (eol_i) begin
      unique case (phase_a)
        hrls_pkg::PH_LEAD: begin
          bump.m_inc = 1'b1;
          bump.m_sel = hrls_pkg::M_OTHER;
          bump.p_inc = 1'b1;
          bump.p_sel = hrls_pkg::P_OTHER;
        end
        hrls_pkg::PH_METHOD: begin
          bump.m_inc = 1'b1;
          bump.m_sel = hrls_pkg::method_pick(mc_a, idx_a);
          bump.p_inc = 1'b1;
          bump.p_sel = hrls_pkg::P_OTHER;
        end
        hrls_pkg::PH_URI: begin
          bump.p_inc = 1'b1;
          bump.p_sel = hrls_pkg::path_pick(pc_a, idx_a);
        end
        hrls_pkg::PH_REST: begin
        end
        default: begin
        end
      endcase
      phase_d = hrls_pkg::PH_LEAD;
      idx_d   = 4'd0;
      mc_d    = '1;
      pc_d    = '1;
    end else begin
      phase_d = phase_a;
      idx_d   = idx_a;
      mc_d    = mc_a;
      pc_d    = pc_a;
    end
  end

  assign bump_o = '{m_inc: bump.m_inc & advance_i, m_sel: bump.m_sel,
                    p_inc: bump.p_inc & advance_i, p_sel: bump.p_sel};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= hrls_pkg::PH_LEAD;
      idx_q   <= 4'd0;
      mc_q    <= '1;
      pc_q    <= '1;
    end else if (advance_i) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      mc_q    <= mc_d;
      pc_q    <= pc_d;
    end
  end

endmodule

FILE: hw/rtl/hrls_counters.sv
// Bank of saturating method and URI counters with 32-bit views of their next values.
// Depends on hrls_pkg; driven by the increments from hrls_parser.
module hrls_counters #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  hrls_pkg::bump_t               bump_i,
  output logic [hrls_pkg::VIEW_BITS-1:0] m_view_o [5],
  output logic [hrls_pkg::VIEW_BITS-1:0] p_view_o [6]
);

  logic [COUNT_BITS-1:0] m_cnt_q [5];
  logic [COUNT_BITS-1:0] m_cnt_d [5];
  logic [COUNT_BITS-1:0] p_cnt_q [6];
  logic [COUNT_BITS-1:0] p_cnt_d [6];

  always_comb begin
    for (int k = 0; k < 5; k++) begin
      m_cnt_d[k] = m_cnt_q[k];
      if (bump_i.m_inc && (bump_i.m_sel == hrls_pkg::method_e'(3'(k))) &&
          (m_cnt_q[k] != '1)) begin
        m_cnt_d[k] = m_cnt_q[k] + 1'b1;
      end
    end
    for (int k = 0; k < 6; k++) begin
      p_cnt_d[k] = p_cnt_q[k];
      if (bump_i.p_inc && (bump_i.p_sel == hrls_pkg::path_e'(3'(k))) &&
          (p_cnt_q[k] != '1)) begin
        p_cnt_d[k] = p_cnt_q[k] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 5; k++) m_cnt_q[k] <= '0;
      for (int k = 0; k < 6; k++) p_cnt_q[k] <= '0;
    end else begin
      for (int k = 0; k < 5; k++) m_cnt_q[k] <= m_cnt_d[k];
      for (int k = 0; k < 6; k++) p_cnt_q[k] <= p_cnt_d[k];
    end
  end

  // The views show the counters as they will be after this cycle's increments.
  // Counters wider than the output view read all ones once they pass it.
  for (genvar g = 0; g < 5; g++) begin : g_m_view
    if (COUNT_BITS > hrls_pkg::VIEW_BITS) begin : g_wide
      assign m_view_o[g] = (|m_cnt_d[g][COUNT_BITS-1:hrls_pkg::VIEW_BITS]) ? '1 :
                           m_cnt_d[g][hrls_pkg::VIEW_BITS-1:0];
    end else begin : g_narrow
      assign m_view_o[g] = hrls_pkg::VIEW_BITS'(m_cnt_d[g]);
    end
  end

  for (genvar g = 0; g < 6; g++) begin : g_p_view
    if (COUNT_BITS > hrls_pkg::VIEW_BITS) begin : g_wide
      assign p_view_o[g] = (|p_cnt_d[g][COUNT_BITS-1:hrls_pkg::VIEW_BITS]) ? '1 :
                           p_cnt_d[g][hrls_pkg::VIEW_BITS-1:0];
    end else begin : g_narrow
      assign p_view_o[g] = hrls_pkg::VIEW_BITS'(p_cnt_d[g]);
    end
  end

endmodule

FILE: hw/rtl/http_request_line_stats.sv
// Top level of the HTTP request line statistics block: input register and handshake.
// Depends on hrls_pkg, hrls_parser and hrls_counters.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+----------------------------------------
//   in      | sink      | in_valid_i/in_stall_o | line_byte_i, end_of_line_i
//   out     | source    | out_valid_o/out_stall_i | eleven 32-bit counter snapshots
//
// One byte word is taken every clock cycle while not stalled; a byte passes the input
// register to the counters, and the result register loads in step with the counters.
// The only stall comes from the output: an end-of-line byte waits in the input
// register while the previous snapshot is still held and stalled.
// Reset clears the parser state, the counters and both valid flags at once.
module http_request_line_stats #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  line_byte_i,
  input  logic        end_of_line_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] get_count_o,
  output logic [31:0] post_count_o,
  output logic [31:0] delete_count_o,
  output logic [31:0] put_count_o,
  output logic [31:0] other_method_count_o,
  output logic [31:0] root_count_o,
  output logic [31:0] order_count_o,
  output logic [31:0] product_count_o,
  output logic [31:0] basket_count_o,
  output logic [31:0] help_count_o,
  output logic [31:0] other_uri_count_o
);

  logic            in_valid_q, in_valid_d;
  logic [7:0]      byte_q;
  logic            eol_q;
  logic            out_valid_q, out_valid_d;
  logic            hold;
  logic            advance;
  hrls_pkg::bump_t bump;
  logic [hrls_pkg::VIEW_BITS-1:0] m_view [5];
  logic [hrls_pkg::VIEW_BITS-1:0] p_view [6];
  logic [hrls_pkg::VIEW_BITS-1:0] snap_m_q [5];
  logic [hrls_pkg::VIEW_BITS-1:0] snap_p_q [6];

  // The counters keep moving while the next line is parsed, since a method is
  // counted as soon as its token ends. An end-of-line byte therefore copies the
  // counters' next values into the result register. Only a second end-of-line
  // byte has to wait while that result is still held and stalled.
  assign hold       = in_valid_q && eol_q && out_valid_q && out_stall_i;
  assign advance    = in_valid_q && !hold;
  assign in_stall_o = hold;

  always_comb begin
    in_valid_d = hold ? in_valid_q : in_valid_i;
    if (advance && eol_q) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload of the input register needs no reset.
  always_ff @(posedge clk_i) begin
    if (!hold) begin
      byte_q <= line_byte_i;
      eol_q  <= end_of_line_i;
    end
  end

  // Result register: the counts as they stand once the line has been counted.
  always_ff @(posedge clk_i) begin
    if (advance && eol_q) begin
      for (int k = 0; k < 5; k++) snap_m_q[k] <= m_view[k];
      for (int k = 0; k < 6; k++) snap_p_q[k] <= p_view[k];
    end
  end

  hrls_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .byte_i    (byte_q),
    .eol_i     (eol_q),
    .bump_o    (bump)
  );

  hrls_counters #(
    .COUNT_BITS (COUNT_BITS)
  ) u_counters (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .bump_i   (bump),
    .m_view_o (m_view),
    .p_view_o (p_view)
  );

  assign out_valid_o          = out_valid_q;
  assign get_count_o          = snap_m_q[hrls_pkg::M_GET];
  assign post_count_o         = snap_m_q[hrls_pkg::M_POST];
  assign delete_count_o       = snap_m_q[hrls_pkg::M_DELETE];
  assign put_count_o          = snap_m_q[hrls_pkg::M_PUT];
  assign other_method_count_o = snap_m_q[hrls_pkg::M_OTHER];
  assign root_count_o         = snap_p_q[hrls_pkg::P_ROOT];
  assign order_count_o        = snap_p_q[hrls_pkg::P_ORDER];
  assign product_count_o      = snap_p_q[hrls_pkg::P_PRODUCT];
  assign basket_count_o       = snap_p_q[hrls_pkg::P_BASKET];
  assign help_count_o         = snap_p_q[hrls_pkg::P_HELP];
  assign other_uri_count_o    = snap_p_q[hrls_pkg::P_OTHER];

endmodule

FILE: hw/rtl/hrls_checker.sv
// Port-level checker for the request line statistics block, bound to its top level.
// Depends on http_request_line_stats_macros.svh.
`include "http_request_line_stats_macros.svh"

module hrls_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_i,
  input logic        out_valid_i,
  input logic        out_stall_i,
  input logic [31:0] get_count_i
);

  `HRLS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && out_stall_i, out_valid_i, "result dropped while stalled")
  `HRLS_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_i && out_stall_i, $stable(get_count_i), "result changed while stalled")
  `HRLS_ASSERT_NOW(a_stall_cause, clk_i, rst_ni, in_stall_i, out_valid_i && out_stall_i, "input stalled without a stalled result")
  `HRLS_ASSERT_NOW(a_result_cause, clk_i, rst_ni, $rose(out_valid_i), !$past(in_stall_i), "result rose while the input was stalled")

endmodule

bind http_request_line_stats hrls_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .get_count_i (get_count_o)
);

FILE: test/tb.sv
// Self-checking bench for the HTTP request line statistics block.
// Depends on hrls_pkg (phase, method and path codes, SPACE_BYTE) and on the
// http_request_line_stats top level; everything else is generated here.
`timescale 1ns / 1ps

module tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_WORDS = 850;
  localparam int IDLE_PCT = 18;
  // Both sides run without idling while the words from CALM_FIRST up to CALM_LAST go through.
  localparam int CALM_FIRST = 250;
  localparam int CALM_LAST = 450;
  localparam int DRAIN_CYCLES = 8;

  // One input word: a line byte plus its end-of-line flag.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } line_word_t;

  // The eleven counters in port order: five methods, then six paths.
  typedef logic [10:0][31:0] tally_set_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  line_byte_i = 8'h00;
  logic        end_of_line_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] get_count_o;
  logic [31:0] post_count_o;
  logic [31:0] delete_count_o;
  logic [31:0] put_count_o;
  logic [31:0] other_method_count_o;
  logic [31:0] root_count_o;
  logic [31:0] order_count_o;
  logic [31:0] product_count_o;
  logic [31:0] basket_count_o;
  logic [31:0] help_count_o;
  logic [31:0] other_uri_count_o;

  http_request_line_stats DUT (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .line_byte_i          (line_byte_i),
    .end_of_line_i        (end_of_line_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .get_count_o          (get_count_o),
    .post_count_o         (post_count_o),
    .delete_count_o       (delete_count_o),
    .put_count_o          (put_count_o),
    .other_method_count_o (other_method_count_o),
    .root_count_o         (root_count_o),
    .order_count_o        (order_count_o),
    .product_count_o      (product_count_o),
    .basket_count_o       (basket_count_o),
    .help_count_o         (help_count_o),
    .other_uri_count_o    (other_uri_count_o)
  );

  // Name tables of the bench's own, in the order of method_e and path_e.
  string method_words [4] = '{"GET", "POST", "DELETE", "PUT"};
  string path_words [5] = '{"/", "/order", "/product", "/basket", "/help"};
  string version_words [3] = '{"HTTP/1.1", "HTTP/1.0", "H"};
  string tally_names [11] = '{"get_count", "post_count", "delete_count", "put_count",
                              "other_method_count", "root_count", "order_count",
                              "product_count", "basket_count", "help_count",
                              "other_uri_count"};

  line_word_t pending_words [$];
  tally_set_t expected_tallies [$];
  logic [7:0] line_bytes [$];

  // Line parser state as the block should hold it.
  hrls_pkg::phase_e  line_phase;
  logic [3:0]        token_len;
  logic [3:0]        method_live;
  logic [4:0]        path_live;
  hrls_pkg::method_e method_seen;
  logic [31:0]       method_tally [5];
  logic [31:0]       path_tally [6];

  int mismatches = 0;
  int words_taken = 0;
  int random_words = 0;
  int cycles = 0;
  bit in_took = 1'b0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Line parser prediction
  // ---------------------------------------------------------------------------

  task automatic clear_line();
    line_phase = hrls_pkg::PH_LEAD;
    token_len = 4'd0;
    method_live = 4'hF;
    path_live = 5'h1F;
    method_seen = hrls_pkg::M_OTHER;
  endtask

  task automatic count_method(input hrls_pkg::method_e m);
    if (method_tally[int'(m)] != '1) begin
      method_tally[int'(m)] = method_tally[int'(m)] + 32'd1;
    end
  endtask

  task automatic count_path(input hrls_pkg::path_e p);
    if (path_tally[int'(p)] != '1) begin
      path_tally[int'(p)] = path_tally[int'(p)] + 32'd1;
    end
  endtask

  // A byte knocks out every name that is too short or has another character here.
  // The token length stops at 15 so that long tokens match nothing.
  task automatic narrow_token(input logic [7:0] b, input bit in_method);
    if (in_method) begin
      for (int k = 0; k < 4; k++) begin
        if (token_len >= method_words[k].len() || method_words[k][token_len] != b) begin
          method_live[k] = 1'b0;
        end
      end
    end else begin
      for (int k = 0; k < 5; k++) begin
        if (token_len >= path_words[k].len() || path_words[k][token_len] != b) begin
          path_live[k] = 1'b0;
        end
      end
    end
    if (token_len != 4'd15) begin
      token_len = token_len + 4'd1;
    end
  endtask

  // The lowest surviving name of exactly the token's length is the match.
  task automatic close_method();
    method_seen = hrls_pkg::M_OTHER;
    for (int k = 3; k >= 0; k--) begin
      if (method_live[k] && method_words[k].len() == token_len) begin
        method_seen = hrls_pkg::method_e'(3'(k));
      end
    end
    count_method(method_seen);
  endtask

  task automatic close_path();
    hrls_pkg::path_e sel;
    sel = hrls_pkg::P_OTHER;
    for (int k = 4; k >= 0; k--) begin
      if (path_live[k] && path_words[k].len() == token_len) begin
        sel = hrls_pkg::path_e'(3'(k));
      end
    end
    count_path(sel);
  endtask

  // Advances the predicted parser by one accepted word and, on the end of a
  // line, queues the counter snapshot that the block must put out.
  task automatic parse_word(input logic [7:0] b, input logic last);
    tally_set_t snap;
    bit is_space;
    is_space = (b == hrls_pkg::SPACE_BYTE);
    case (line_phase)
      hrls_pkg::PH_LEAD: begin
        if (!is_space) begin
          line_phase = hrls_pkg::PH_METHOD;
          token_len = 4'd0;
          method_live = 4'hF;
          narrow_token(b, 1'b1);
        end
      end
      hrls_pkg::PH_METHOD: begin
        if (is_space) begin
          close_method();
          line_phase = hrls_pkg::PH_URI;
          token_len = 4'd0;
          path_live = 5'h1F;
        end else begin
          narrow_token(b, 1'b1);
        end
      end
      hrls_pkg::PH_URI: begin
        if (is_space) begin
          close_path();
          line_phase = hrls_pkg::PH_REST;
        end else begin
          narrow_token(b, 1'b0);
        end
      end
      default: begin
      end
    endcase
    if (last) begin
      // A line that ends early still counts one method and one URI: a blank
      // line is unknown for both, a line without a URI has an unknown URI.
      case (line_phase)
        hrls_pkg::PH_LEAD: begin
          count_method(hrls_pkg::M_OTHER);
          count_path(hrls_pkg::P_OTHER);
        end
        hrls_pkg::PH_METHOD: begin
          close_method();
          count_path(hrls_pkg::P_OTHER);
        end
        hrls_pkg::PH_URI: begin
          close_path();
        end
        default: begin
        end
      endcase
      for (int k = 0; k < 5; k++) begin
        snap[k] = method_tally[k];
      end
      for (int k = 0; k < 6; k++) begin
        snap[5 + k] = path_tally[k];
      end
      expected_tallies.push_back(snap);
      clear_line();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Line building
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] rand_glyph();
    logic [7:0] g;
    do begin
      g = 8'($urandom_range(255));
    end while (g == hrls_pkg::SPACE_BYTE);
    return g;
  endfunction

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      line_bytes.push_back(s[i]);
    end
  endtask

  // Puts a known name, or a near miss of it: one byte short, one byte long,
  // one byte replaced, or one byte with its case bit 0x20 flipped.
  task automatic put_name(input string s, input bit mangle);
    int first;
    logic [7:0] dropped;
    first = line_bytes.size();
    put_text(s);
    if (mangle) begin
      case ($urandom_range(3))
        0: dropped = line_bytes.pop_back();
        1: line_bytes.push_back(rand_glyph());
        2: line_bytes[first + $urandom_range(s.len() - 1)] = rand_glyph();
        default: line_bytes[first + $urandom_range(s.len() - 1)] ^= 8'h20;
      endcase
    end
  endtask

  task automatic put_junk_token();
    int n;
    n = $urandom_range(18, 1);
    for (int i = 0; i < n; i++) begin
      line_bytes.push_back(rand_glyph());
    end
  endtask

  // Moves the built line into the pending words, flag on its last byte.
  task automatic flush_line();
    line_word_t w;
    if (line_bytes.size() == 0) begin
      line_bytes.push_back(hrls_pkg::SPACE_BYTE);
    end
    for (int i = 0; i < line_bytes.size(); i++) begin
      w.data = line_bytes[i];
      w.last = (i == line_bytes.size() - 1);
      pending_words.push_back(w);
    end
    random_words += line_bytes.size();
    line_bytes.delete();
  endtask

  // Mostly well-formed lines with random content; the rest is noise or
  // lines cut off at a random byte.
  task automatic make_random_line();
    int pick;
    int keep;
    logic [7:0] dropped;
    if ($urandom_range(99) < 12) begin
      keep = $urandom_range(16, 1);
      for (int i = 0; i < keep; i++) begin
        if ($urandom_range(9) < 3) begin
          line_bytes.push_back(hrls_pkg::SPACE_BYTE);
        end else begin
          line_bytes.push_back(8'($urandom_range(255)));
        end
      end
    end else begin
      if ($urandom_range(9) == 0) begin
        keep = $urandom_range(3, 1);
        for (int i = 0; i < keep; i++) begin
          line_bytes.push_back(hrls_pkg::SPACE_BYTE);
        end
      end
      pick = $urandom_range(99);
      if (pick < 80) begin
        put_name(method_words[$urandom_range(3)], 1'b0);
      end else if (pick < 90) begin
        put_name(method_words[$urandom_range(3)], 1'b1);
      end else begin
        put_junk_token();
      end
      if ($urandom_range(19) != 0) begin
        line_bytes.push_back(hrls_pkg::SPACE_BYTE);
        if ($urandom_range(99) < 8) begin
          line_bytes.push_back(hrls_pkg::SPACE_BYTE);
        end
        pick = $urandom_range(99);
        if (pick < 75) begin
          put_name(path_words[$urandom_range(4)], 1'b0);
        end else if (pick < 90) begin
          put_name(path_words[$urandom_range(4)], 1'b1);
        end else begin
          put_junk_token();
        end
        if ($urandom_range(1) == 0) begin
          line_bytes.push_back(hrls_pkg::SPACE_BYTE);
          put_text(version_words[$urandom_range(2)]);
        end
      end
      if ($urandom_range(99) < 8) begin
        keep = $urandom_range(line_bytes.size(), 1);
        while (line_bytes.size() > keep) begin
          dropped = line_bytes.pop_back();
        end
      end
    end
    flush_line();
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin
    clear_line();
    for (int k = 0; k < 5; k++) begin
      method_tally[k] = '0;
    end
    for (int k = 0; k < 6; k++) begin
      path_tally[k] = '0;
    end

    // Directed lines: a plain match, a leading space with no URI, a blank line,
    // a second space that leaves the URI empty, the byte extremes as a method,
    // and a version field after a full request.
    put_text("GET /");
    flush_line();
    put_text(" PUT");
    flush_line();
    put_text(" ");
    flush_line();
    put_text("X  ");
    flush_line();
    line_bytes.push_back(8'h00);
    line_bytes.push_back(8'hFF);
    flush_line();
    put_text("POST /help x");
    flush_line();

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Hold back the random lines until the directed lines have drained completely.
    while (pending_words.size() != 0 || in_valid_i || expected_tallies.size() != 0) begin
      @(posedge clk_i);
    end

    random_words = 0;
    while (random_words < RANDOM_WORDS) begin
      make_random_line();
    end

    while (pending_words.size() != 0 || in_valid_i || expected_tallies.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && expected_tallies.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: new words and stall decisions go out at the falling edge.
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin : driver
    line_word_t w;
    bit calm;
    if (rst_ni) begin
      calm = (words_taken >= CALM_FIRST && words_taken < CALM_LAST);
      out_stall_i <= !calm && ($urandom_range(99) < IDLE_PCT);
      // A word that is offered stays put until the block takes it.
      if (!in_valid_i || in_took) begin
        if (pending_words.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          w = pending_words.pop_front();
          in_valid_i <= 1'b1;
          line_byte_i <= w.data;
          end_of_line_i <= w.last;
        end else begin
          in_valid_i <= 1'b0;
          line_byte_i <= 8'($urandom_range(255));
          end_of_line_i <= 1'($urandom_range(1));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: both handshakes are sampled at the rising edge. An accepted input
  // word feeds the prediction; an accepted result is checked against the
  // oldest snapshot still owed.
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : monitor
    tally_set_t seen;
    tally_set_t owed;
    if (rst_ni) begin
      in_took = in_valid_i && !in_stall_o;
      if (in_took) begin
        parse_word(line_byte_i, end_of_line_i);
        words_taken++;
      end
      if (out_valid_o && !out_stall_i) begin
        seen[0] = get_count_o;
        seen[1] = post_count_o;
        seen[2] = delete_count_o;
        seen[3] = put_count_o;
        seen[4] = other_method_count_o;
        seen[5] = root_count_o;
        seen[6] = order_count_o;
        seen[7] = product_count_o;
        seen[8] = basket_count_o;
        seen[9] = help_count_o;
        seen[10] = other_uri_count_o;
        if (expected_tallies.size() == 0) begin
          $display("%0t: result word with none expected, expected nothing, got get_count %0d",
                   $time, seen[0]);
          mismatches++;
        end else begin
          owed = expected_tallies.pop_front();
          for (int k = 0; k < 11; k++) begin
            if (seen[k] !== owed[k]) begin
              $display("%0t: %s expected %0d, got %0d", $time, tally_names[k], owed[k],
                       seen[k]);
              mismatches++;
            end
          end
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule
